FILE: rtl/core/mqsc_pkg.sv
// Shared types and constants for the client packet statement counter.
// No dependencies; imported by the front, queue, back and top modules.
package mqsc_pkg;

	localparam int MQSC_COUNT_BITS = 16;
	localparam int MQSC_QDEPTH     = 4;
	localparam int MQSC_QPTR_BITS  = $clog2(MQSC_QDEPTH);
	localparam int MQSC_QCNT_BITS  = $clog2(MQSC_QDEPTH + 1);

	localparam logic [7:0] CMD_QUERY   = 8'h03;
	localparam logic [7:0] CMD_PREPARE = 8'h16;
	localparam logic [7:0] CH_SEMI     = 8'h3B;
	localparam logic [7:0] CH_BSLASH   = 8'h5C;
	localparam logic [7:0] CH_SQUOTE   = 8'h27;
	localparam logic [7:0] CH_DQUOTE   = 8'h22;
	localparam logic [7:0] CH_SPACE    = 8'h20;
	localparam logic [7:0] CH_TAB      = 8'h09;
	localparam logic [7:0] CH_CR       = 8'h0D;

	typedef enum logic [1:0] {
		KIND_CMD,
		KIND_TEXT,
		KIND_EMPTY
	} kind_t;

	typedef struct packed {
		kind_t       kind;
		logic [7:0]  data;
		logic        last;
		logic [23:0] length;
		logic [7:0]  seq;
	} entry_t;

	typedef struct packed {
		logic                      full;
		logic                      empty;
		logic [MQSC_QCNT_BITS-1:0] count;
	} qstat_t;

endpackage

FILE: rtl/core/mqsc_front.sv
// Header parser: accepts stream bytes and tags payload bytes for the back end.
// Depends on mqsc_pkg.
module mqsc_front
	import mqsc_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       take,
	input  logic [7:0] data_byte,
	output logic       push,
	output entry_t     push_entry
);

	typedef enum logic [2:0] {
		PH_LEN0,
		PH_LEN1,
		PH_LEN2,
		PH_SEQ,
		PH_CMD,
		PH_TEXT
	} phase_t;

	phase_t      phase_q;
	logic [23:0] len_q;
	logic [23:0] rem_q;
	logic [7:0]  seq_q;
	logic [23:0] rem_dec;
	logic        rem_last;

	assign rem_dec  = rem_q - 24'd1;
	assign rem_last = (rem_dec == 24'd0);

	always_comb begin
		push              = 1'b0;
		push_entry.kind   = KIND_TEXT;
		push_entry.data   = data_byte;
		push_entry.last   = rem_last;
		push_entry.length = len_q;
		push_entry.seq    = seq_q;
		case (phase_q)
			PH_LEN0, PH_LEN1, PH_LEN2: begin
				push = 1'b0;
			end
			PH_SEQ: begin
				push              = take && (len_q == 24'd0);
				push_entry.kind   = KIND_EMPTY;
				push_entry.last   = 1'b1;
				push_entry.seq    = data_byte;
			end
			PH_CMD: begin
				push            = take;
				push_entry.kind = KIND_CMD;
			end
			default: begin
				push = take;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_LEN0;
			len_q   <= '0;
			rem_q   <= '0;
			seq_q   <= '0;
		end else if (take) begin
			case (phase_q)
				PH_LEN0: begin
					len_q   <= {16'd0, data_byte};
					phase_q <= PH_LEN1;
				end
				PH_LEN1: begin
					len_q[15:8] <= data_byte;
					phase_q     <= PH_LEN2;
				end
				PH_LEN2: begin
					len_q[23:16] <= data_byte;
					phase_q      <= PH_SEQ;
				end
				PH_SEQ: begin
					seq_q   <= data_byte;
					rem_q   <= len_q;
					phase_q <= (len_q == 24'd0) ? PH_LEN0 : PH_CMD;
				end
				default: begin
					rem_q   <= rem_dec;
					phase_q <= rem_last ? PH_LEN0 : PH_TEXT;
				end
			endcase
		end
	end

endmodule

FILE: rtl/core/mqsc_fifo.sv
// Short queue of tagged bytes between the header parser and the text scanner.
// Depends on mqsc_pkg.
module mqsc_fifo
	import mqsc_pkg::*;
(
	input  logic   clk,
	input  logic   arst_n,
	input  logic   push,
	input  entry_t push_entry,
	input  logic   pop,
	output entry_t head,
	output qstat_t stat
);

	entry_t                    mem_q [MQSC_QDEPTH];
	logic [MQSC_QPTR_BITS-1:0] wptr_q;
	logic [MQSC_QPTR_BITS-1:0] rptr_q;
	logic [MQSC_QCNT_BITS-1:0] cnt_q;

	assign head       = mem_q[rptr_q];
	assign stat.count = cnt_q;
	assign stat.full  = (cnt_q == MQSC_QCNT_BITS'(MQSC_QDEPTH));
	assign stat.empty = (cnt_q == '0);

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (push) begin
				wptr_q <= wptr_q + 1'b1;
			end
			if (pop) begin
				rptr_q <= rptr_q + 1'b1;
			end
			unique case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

FILE: rtl/core/mqsc_back.sv
// Text scanner and result register: counts statements, emits one result per packet.
// Depends on mqsc_pkg.
module mqsc_back
	import mqsc_pkg::*;
#(
	parameter int COUNT_BITS = MQSC_COUNT_BITS
) (
	input  logic        clk,
	input  logic        arst_n,
	input  entry_t      head,
	input  logic        head_valid,
	output logic        pop,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [23:0] payload_length,
	output logic [7:0]  sequence_id,
	output logic [7:0]  command,
	output logic        is_query,
	output logic        is_prepare,
	output logic [15:0] statement_count
);

	localparam int CW = (COUNT_BITS > 16) ? COUNT_BITS : 16;
	localparam logic [COUNT_BITS-1:0] TALLY_MAX = '1;

	logic [7:0]            cmd_q;
	logic                  esc_q;
	logic                  inq_q;
	logic                  dbl_q;
	logic                  run_q;
	logic                  semi_q;
	logic [COUNT_BITS-1:0] tally_q;

	logic [7:0]            cmd_n;
	logic                  esc_n;
	logic                  inq_n;
	logic                  dbl_n;
	logic                  run_n;
	logic                  semi_n;
	logic [COUNT_BITS-1:0] tally_n;

	logic                  blank;
	logic [7:0]            b;
	logic [7:0]            emit_cmd;
	logic                  emit_q;
	logic [COUNT_BITS-1:0] cnt;
	logic [CW-1:0]         cnt_w;
	logic [15:0]           cnt_out;

	assign b     = head.data;
	assign blank = (b == CH_SPACE) || ((b >= CH_TAB) && (b <= CH_CR));
	assign pop   = head_valid && (!head.last || !out_valid || !out_stall);

	always_comb begin
		cmd_n   = cmd_q;
		esc_n   = esc_q;
		inq_n   = inq_q;
		dbl_n   = dbl_q;
		run_n   = run_q;
		semi_n  = semi_q;
		tally_n = tally_q;
		case (head.kind)
			KIND_CMD: begin
				cmd_n   = b;
				esc_n   = 1'b0;
				inq_n   = 1'b0;
				dbl_n   = 1'b0;
				run_n   = 1'b0;
				semi_n  = 1'b0;
				tally_n = COUNT_BITS'(1);
			end
			KIND_TEXT: begin
				if (run_q && (b == CH_SEMI)) begin
					semi_n = 1'b1;
				end else begin
					run_n = 1'b0;
					if (!blank) begin
						semi_n = (b == CH_SEMI);
					end
					priority if (esc_q) begin
						esc_n = 1'b0;
					end else if (b == CH_BSLASH) begin
						esc_n = 1'b1;
					end else if (((b == CH_SQUOTE) || (b == CH_DQUOTE)) && !inq_q) begin
						inq_n = 1'b1;
						dbl_n = (b == CH_DQUOTE);
					end else if (inq_q && (b == (dbl_q ? CH_DQUOTE : CH_SQUOTE))) begin
						inq_n = 1'b0;
					end else if ((b == CH_SEMI) && !inq_q) begin
						if (tally_q != TALLY_MAX) begin
							tally_n = tally_q + 1'b1;
						end
						run_n = 1'b1;
					end else begin
						esc_n = esc_q;
					end
				end
			end
			default: begin
				cmd_n = cmd_q;
			end
		endcase
	end

	assign emit_cmd = (head.kind == KIND_EMPTY) ? 8'd0 : cmd_n;
	assign emit_q   = (emit_cmd == CMD_QUERY);

	always_comb begin
		if (!emit_q) begin
			cnt = '0;
		end else if (tally_n == TALLY_MAX) begin
			cnt = TALLY_MAX;
		end else begin
			cnt = tally_n - COUNT_BITS'(semi_n);
		end
		cnt_w   = CW'(cnt);
		cnt_out = (cnt_w > CW'(16'hFFFF)) ? 16'hFFFF : cnt_w[15:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_q   <= '0;
			esc_q   <= 1'b0;
			inq_q   <= 1'b0;
			dbl_q   <= 1'b0;
			run_q   <= 1'b0;
			semi_q  <= 1'b0;
			tally_q <= COUNT_BITS'(1);
		end else if (pop) begin
			cmd_q   <= cmd_n;
			esc_q   <= esc_n;
			inq_q   <= inq_n;
			dbl_q   <= dbl_n;
			run_q   <= run_n;
			semi_q  <= semi_n;
			tally_q <= tally_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (pop && head.last) begin
			out_valid <= 1'b1;
		end else if (!out_stall) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop && head.last) begin
			payload_length  <= head.length;
			sequence_id     <= head.seq;
			command         <= emit_cmd;
			is_query        <= emit_q;
			is_prepare      <= (emit_cmd == CMD_PREPARE);
			statement_count <= cnt_out;
		end
	end

endmodule

FILE: rtl/core/mysql_query_statement_counter.sv
// Top level of the client packet statement counter: front parser, queue, back scanner.
// Depends on mqsc_pkg, mqsc_front, mqsc_fifo and mqsc_back.
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+------------------------------------------
//   input   | in        | in_valid / in_stall  | data_byte
//   output  | out       | out_valid / out_stall| payload_length, sequence_id, command,
//           |           |                      | is_query, is_prepare, statement_count
//
// One byte per cycle while in_stall is low; the final byte of a packet passes a queue
// write, then a scan into the output register, where its result appears.
// in_stall rises only when the four-entry queue is full; out_stall backs up into it.
// arst_n clears the parser, queue pointers, scanner state and output valid.
module mysql_query_statement_counter
	import mqsc_pkg::*;
#(
	parameter int COUNT_BITS = MQSC_COUNT_BITS
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  data_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [23:0] payload_length,
	output logic [7:0]  sequence_id,
	output logic [7:0]  command,
	output logic        is_query,
	output logic        is_prepare,
	output logic [15:0] statement_count
);

	logic   take;
	logic   push;
	logic   pop;
	entry_t push_entry;
	entry_t head;
	qstat_t qstat;

	assign in_stall = qstat.full;
	assign take     = in_valid && !in_stall;

	mqsc_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.take       (take),
		.data_byte  (data_byte),
		.push       (push),
		.push_entry (push_entry)
	);

	mqsc_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.pop        (pop),
		.head       (head),
		.stat       (qstat)
	);

	mqsc_back #(
		.COUNT_BITS (COUNT_BITS)
	) u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.head            (head),
		.head_valid      (!qstat.empty),
		.pop             (pop),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.payload_length  (payload_length),
		.sequence_id     (sequence_id),
		.command         (command),
		.is_query        (is_query),
		.is_prepare      (is_prepare),
		.statement_count (statement_count)
	);

	a_queue_bound: assert property (@(posedge clk) disable iff (!arst_n)
		qstat.count <= MQSC_QCNT_BITS'(MQSC_QDEPTH))
		else $error("queue count beyond depth");

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		qstat.full && !pop |=> $stable(qstat.count))
		else $error("queue written while full");

	a_empty_packet: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (payload_length == 24'd0) |-> (command == 8'd0) &&
		(statement_count == 16'd0) && !is_query && !is_prepare)
		else $error("empty packet result carries command data");

	a_nonquery_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !is_query |-> (statement_count == 16'd0))
		else $error("statement count on non-query result");

endmodule

FILE: tb/tb_mysql_query_statement_counter.sv
// Self-checking testbench for mysql_query_statement_counter: packets in, one result each.
// A byte-level predictor builds expected results; the driver idles and the output stalls at random.
// Depends on mqsc_pkg and the mysql_query_statement_counter top level.
`timescale 1ns / 100ps

module tb_mysql_query_statement_counter;
	import mqsc_pkg::*;

	localparam longint unsigned TALLY_MAX = (64'd1 << MQSC_COUNT_BITS) - 1;
	localparam int unsigned CYCLE_LIMIT = 200_000;
	localparam int unsigned RANDOM_BYTES = 1300;

	typedef struct {
		logic [7:0]  data;
		int unsigned gap;
		bit          drain;
	} stream_byte_t;

	typedef struct {
		logic [23:0] length;
		logic [7:0]  seq;
		logic [7:0]  cmd;
		logic        query;
		logic        prepare;
		logic [15:0] count;
	} packet_result_t;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [7:0]  data_byte;
	logic        out_valid;
	logic        out_stall;
	logic [23:0] payload_length;
	logic [7:0]  sequence_id;
	logic [7:0]  command;
	logic        is_query;
	logic        is_prepare;
	logic [15:0] statement_count;

	stream_byte_t   byte_stream_q[$];
	packet_result_t pending_results[$];
	logic [7:0]     sql_text[$];

	bit          run_on;
	bit          calm_tx;
	bit          drain_next;
	stream_byte_t pend;
	bit          pend_loaded;
	int unsigned gap_left;
	int unsigned stall_left;
	int unsigned bytes_offered;
	int unsigned bytes_taken;
	int unsigned stream_total;
	int unsigned packets_built;
	int unsigned cycles;
	int unsigned mismatches;
	int unsigned results_seen;
	int unsigned queries_seen;
	int unsigned saturated_seen;

	logic [2:0]      hdr_phase;
	logic [23:0]     len_acc;
	logic [23:0]     remaining;
	logic [7:0]      seq_r;
	logic [7:0]      cmd_r;
	bit              esc;
	bit              in_quote;
	bit              dquote;
	bit              semi_run;
	bit              ends_semi;
	longint unsigned tally;

	mysql_query_statement_counter i_dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.data_byte       (data_byte),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.payload_length  (payload_length),
		.sequence_id     (sequence_id),
		.command         (command),
		.is_query        (is_query),
		.is_prepare      (is_prepare),
		.statement_count (statement_count)
	);

	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	function automatic bit is_blank(input logic [7:0] b);
		return b == CH_SPACE || (b >= CH_TAB && b <= CH_CR);
	endfunction

	function automatic void close_packet(input bit no_payload);
		packet_result_t r;
		longint unsigned cnt;
		cnt = 0;
		r.length = len_acc;
		r.seq = seq_r;
		r.cmd = no_payload ? 8'h00 : cmd_r;
		r.query = (r.cmd == CMD_QUERY);
		r.prepare = (r.cmd == CMD_PREPARE);
		if (r.query) begin
			if (tally >= TALLY_MAX)
				cnt = TALLY_MAX;
			else
				cnt = tally - (ends_semi ? 1 : 0);
			if (cnt > 64'hFFFF)
				cnt = 64'hFFFF;
		end
		r.count = cnt[15:0];
		pending_results.push_back(r);
	endfunction

	function automatic void scan_sql(input logic [7:0] b);
		if (semi_run && b == CH_SEMI) begin
			ends_semi = 1'b1;
		end else begin
			semi_run = 1'b0;
			if (!is_blank(b))
				ends_semi = (b == CH_SEMI);
			if (esc) begin
				esc = 1'b0;
			end else if (b == CH_BSLASH) begin
				esc = 1'b1;
			end else if ((b == CH_SQUOTE || b == CH_DQUOTE) && !in_quote) begin
				in_quote = 1'b1;
				dquote = (b == CH_DQUOTE);
			end else if (in_quote && b == (dquote ? CH_DQUOTE : CH_SQUOTE)) begin
				in_quote = 1'b0;
			end else if (b == CH_SEMI && !in_quote) begin
				if (tally < TALLY_MAX)
					tally++;
				semi_run = 1'b1;
			end
		end
	endfunction

	function automatic void absorb_byte(input logic [7:0] b);
		case (hdr_phase)
			3'd0: begin
				len_acc = {16'h0000, b};
				hdr_phase = 3'd1;
			end
			3'd1: begin
				len_acc[15:8] = b;
				hdr_phase = 3'd2;
			end
			3'd2: begin
				len_acc[23:16] = b;
				hdr_phase = 3'd3;
			end
			3'd3: begin
				seq_r = b;
				remaining = len_acc;
				if (remaining == 24'd0) begin
					hdr_phase = 3'd0;
					close_packet(1'b1);
				end else begin
					hdr_phase = 3'd4;
				end
			end
			default: begin
				if (hdr_phase == 3'd4) begin
					cmd_r = b;
					esc = 1'b0;
					in_quote = 1'b0;
					dquote = 1'b0;
					semi_run = 1'b0;
					ends_semi = 1'b0;
					tally = 1;
					hdr_phase = 3'd5;
				end else begin
					scan_sql(b);
				end
				remaining = remaining - 24'd1;
				if (remaining == 24'd0) begin
					hdr_phase = 3'd0;
					close_packet(1'b0);
				end
			end
		endcase
	endfunction

	function automatic int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 88)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic logic [7:0] pick_sql_byte();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 18)
			return CH_SEMI;
		if (r < 24)
			return CH_SQUOTE;
		if (r < 29)
			return CH_DQUOTE;
		if (r < 35)
			return CH_BSLASH;
		if (r < 44)
			return CH_SPACE;
		if (r < 50)
			return 8'($urandom_range(CH_TAB, CH_CR));
		if (r < 85)
			return 8'h61 + 8'($urandom_range(0, 25));
		return 8'($urandom_range(0, 255));
	endfunction

	function automatic void push_byte(input logic [7:0] b);
		stream_byte_t s;
		s.data = b;
		s.gap = calm_tx ? 0 : pick_gap();
		s.drain = drain_next;
		drain_next = 1'b0;
		byte_stream_q.push_back(s);
	endfunction

	function automatic void queue_packet(input logic [7:0] seq, input bit has_cmd,
		input logic [7:0] cmd);
		logic [23:0] len;
		len = has_cmd ? 24'(sql_text.size() + 1) : 24'd0;
		push_byte(len[7:0]);
		push_byte(len[15:8]);
		push_byte(len[23:16]);
		push_byte(seq);
		if (has_cmd) begin
			push_byte(cmd);
			foreach (sql_text[i])
				push_byte(sql_text[i]);
		end
		sql_text.delete();
		packets_built++;
	endfunction

	function automatic void text_from_string(input string s);
		sql_text.delete();
		for (int i = 0; i < s.len(); i++)
			sql_text.push_back(s[i]);
	endfunction

	task automatic cmp_field(input string what, input logic [23:0] want, input logic [23:0] got);
		if (want !== got) begin
			mismatches++;
			$display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, got);
		end
	endtask

	// hold a stalled transfer, otherwise advance to the next byte or idle
	always @(negedge clk) begin
		if (run_on && !(in_valid && bytes_taken != bytes_offered)) begin
			if (!pend_loaded && byte_stream_q.size() != 0) begin
				pend = byte_stream_q.pop_front();
				pend_loaded = 1'b1;
				gap_left = pend.gap;
			end
			if (pend_loaded && gap_left == 0 && !(pend.drain && pending_results.size() != 0)) begin
				in_valid <= 1'b1;
				data_byte <= pend.data;
				bytes_offered++;
				pend_loaded = 1'b0;
			end else begin
				if (gap_left != 0)
					gap_left--;
				in_valid <= 1'b0;
				data_byte <= 8'($urandom);
			end
		end
	end

	always @(negedge clk) begin
		if (run_on) begin
			if (stall_left != 0) begin
				out_stall <= 1'b1;
				stall_left--;
			end else begin
				out_stall <= 1'b0;
				if (cycles[8:7] != 2'b00 && $urandom_range(0, 2) == 0)
					stall_left = pick_gap();
			end
		end
	end

	always @(posedge clk) begin
		if (run_on && in_valid && !in_stall) begin
			absorb_byte(data_byte);
			bytes_taken++;
		end
	end

	always @(posedge clk) begin : result_monitor
		packet_result_t want;
		if (run_on && out_valid && !out_stall) begin
			if (pending_results.size() == 0) begin
				mismatches++;
				$display("%0t: result with none expected, length %0d seq %0d count %0d",
					$time, payload_length, sequence_id, statement_count);
			end else begin
				want = pending_results.pop_front();
				cmp_field("payload_length", want.length, payload_length);
				cmp_field("sequence_id", 24'(want.seq), 24'(sequence_id));
				cmp_field("command", 24'(want.cmd), 24'(command));
				cmp_field("is_query", 24'(want.query), 24'(is_query));
				cmp_field("is_prepare", 24'(want.prepare), 24'(is_prepare));
				cmp_field("statement_count", 24'(want.count), 24'(statement_count));
				results_seen++;
				if (want.query)
					queries_seen++;
				if (want.count == 16'hFFFF)
					saturated_seen++;
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d bytes taken", cycles, bytes_taken);
			$display("tb_mysql_query_statement_counter NOT OK");
			$finish;
		end
	end

	initial begin
		int unsigned r;
		int unsigned n;
		int unsigned random_start;
		logic [7:0] cmd;
		arst_n = 1'b0;
		in_valid = 1'b0;
		data_byte = 8'h00;
		out_stall = 1'b0;
		hdr_phase = 3'd0;
		len_acc = 24'd0;
		remaining = 24'd0;
		seq_r = 8'h00;
		cmd_r = 8'h00;
		tally = 1;

		// directed packets
		queue_packet(8'hFF, 1'b0, 8'h00);
		text_from_string("");
		queue_packet(8'h00, 1'b1, CMD_QUERY);
		text_from_string("\t\n\v\f\r ");
		queue_packet(8'h01, 1'b1, CMD_QUERY);
		text_from_string("a;b");
		queue_packet(8'h02, 1'b1, CMD_PREPARE);
		text_from_string("x;;y ;; ");
		queue_packet(8'h03, 1'b1, CMD_QUERY);
		text_from_string("'a;\"';\\;\"b;'\";");
		queue_packet(8'h04, 1'b1, CMD_QUERY);
		text_from_string("z;");
		queue_packet(8'h80, 1'b1, 8'hFF);

		random_start = byte_stream_q.size();
		drain_next = 1'b1;
		while (byte_stream_q.size() - random_start < RANDOM_BYTES) begin
			if (packets_built % 10 == 0)
				calm_tx = ($urandom_range(0, 4) == 0);
			if ($urandom_range(0, 29) == 0)
				drain_next = 1'b1;
			r = $urandom_range(0, 99);
			if (r < 55)
				cmd = CMD_QUERY;
			else if (r < 65)
				cmd = CMD_PREPARE;
			else
				cmd = 8'($urandom_range(0, 255));
			r = $urandom_range(0, 99);
			if (r < 5) begin
				queue_packet(8'($urandom), 1'b0, 8'h00);
			end else begin
				if (r < 80)
					n = $urandom_range(0, 24);
				else if (r < 97)
					n = $urandom_range(25, 120);
				else
					n = $urandom_range(121, 400);
				for (int i = 0; i < n; i++)
					sql_text.push_back(pick_sql_byte());
				queue_packet(8'($urandom), 1'b1, cmd);
			end
		end
		stream_total = byte_stream_q.size();

		repeat (10) @(negedge clk);
		arst_n <= 1'b1;
		run_on <= 1'b1;

		while (bytes_taken != stream_total)
			@(negedge clk);
		n = 0;
		while (pending_results.size() != 0)
			@(negedge clk);
		repeat (40) @(negedge clk);

		$display("%0d packets in %0d bytes: %0d results checked, %0d queries, %0d saturated",
			packets_built, stream_total, results_seen, queries_seen, saturated_seen);
		if (mismatches == 0 && pending_results.size() == 0) begin
			$display("tb_mysql_query_statement_counter OK");
		end else begin
			$display("%0d mismatches, %0d results missing", mismatches, pending_results.size());
			$display("tb_mysql_query_statement_counter NOT OK");
		end
		$finish;
	end

endmodule

FILE: filelist.f
rtl/core/mqsc_pkg.sv
rtl/core/mqsc_front.sv
rtl/core/mqsc_fifo.sv
rtl/core/mqsc_back.sv
rtl/core/mysql_query_statement_counter.sv
tb/tb_mysql_query_statement_counter.sv
